// ===== hw/rtl/htlp_pkg.sv =====
// Package for the linear-probing hash table.
// Holds command, result and slot-state codes and fixed key constants.
// No dependencies.
`default_nettype none

package htlp_pkg;

    // Width of a key and the shift applied before taking the home slot
    localparam int KEY_W      = 64;
    localparam int HASH_SHIFT = 3;

    // Width of the per-slot state code stored next to the key
    localparam int ST_W = 2;

    // Input command codes; the unused code changes nothing and answers a miss
    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_HIT  = 2'd1,
        RES_MISS = 2'd2,
        RES_FULL = 2'd3
    } t_res;

    // Slot states; code 2 (ST_TOMB) is the tombstone and code 3 is never written
    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

endpackage

`default_nettype wire

// ===== hw/rtl/htlp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the slot key/state store and the slot value store. No dependencies.
`default_nettype none

module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read (read returns data before a same-cycle write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/htlp_home.sv =====
// Home slot unit: computes (key >> 3) mod SLOTS.
// Power-of-two SLOTS: done in the cycle after start. Otherwise a load step, then
// 8 bits of remainder per cycle until the 64-bit shifted key is consumed.
// Depends on htlp_pkg.
`default_nettype none

module htlp_home #(
    parameter int SLOTS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [htlp_pkg::KEY_W-1:0]   i_key,
    output logic                              o_done,
    output logic      [$clog2(SLOTS)-1:0]     o_slot
);

    localparam int IDX_W = $clog2(SLOTS);

    generate
        if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
            // Modulo by a power of two is a bit slice
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    o_done <= 1'b0;
                end else begin
                    o_done <= i_start;
                end
                if (i_start) begin
                    o_slot <= i_key[htlp_pkg::HASH_SHIFT +: IDX_W];
                end
            end
        end else begin : g_serial
            localparam int DIGIT_W = 8;
            localparam int STEPS   = htlp_pkg::KEY_W / DIGIT_W;

            logic [htlp_pkg::KEY_W-1:0]  r_word;
            logic [IDX_W:0]              r_rem;
            logic [$clog2(STEPS)-1:0]    r_step;
            logic                        r_busy;
            logic [IDX_W:0]              n_rem;

            // Restoring remainder over one digit, most significant bit first
            always_comb begin
                n_rem = r_rem;
                for (int b = DIGIT_W - 1; b >= 0; b--) begin
                    n_rem = {n_rem[IDX_W-1:0], r_word[htlp_pkg::KEY_W - DIGIT_W + b]};
                    if (n_rem >= (IDX_W + 1)'(SLOTS)) begin
                        n_rem = n_rem - (IDX_W + 1)'(SLOTS);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                    o_done <= 1'b0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                    o_done <= 1'b0;
                end else if (r_busy) begin
                    r_step <= r_step + 1'b1;
                    if (r_step == ($clog2(STEPS))'(STEPS - 1)) begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end else begin
                        o_done <= 1'b0;
                    end
                end else begin
                    o_done <= 1'b0;
                end

                // Datapath: load shifted key, then consume one digit a cycle
                if (i_start) begin
                    r_word <= i_key >> htlp_pkg::HASH_SHIFT;
                    r_rem  <= '0;
                end else if (r_busy) begin
                    r_word <= r_word << DIGIT_W;
                    r_rem  <= n_rem;
                end
            end

            assign o_slot = r_rem[IDX_W-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/hash_table_linear_probe_top.sv =====
// Hash table with linear probing and tombstone removal.
// Input channel (i_valid / o_stall): one transaction carries a command
// (store, get, remove), a 64-bit key and a value. Output channel
// (o_valid / i_stall): one transaction per input, with status and found value.
// Slot keys and states live in one RAM, slot values in a second RAM; both are
// read once per probe step through a registered read.
// One item is processed at a time. After acceptance an item passes the home
// slot unit, then the probe, one probe step per cycle and one slot per step up
// to SLOTS, set by the RAM read loop, then the result register. The input
// reopens once the result register is loaded. A command of 3 skips the home
// slot unit and the probe and goes straight to the result register.
// After reset the block runs a clearing pass over every slot of the state RAM
// and holds o_stall high meanwhile.
// When the receiver stalls, the result waits in the output register; the next
// item is accepted and probed, and only its completion waits for the register.
// Depends on htlp_pkg, htlp_ram, htlp_home.
`default_nettype none

module hash_table_linear_probe_top #(
    parameter int SLOTS       = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_command,
    input  wire logic [htlp_pkg::KEY_W-1:0]  i_lookup_key,
    input  wire logic [VALUE_WIDTH-1:0]      i_entry_value,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [1:0]                  o_status,
    output logic      [VALUE_WIDTH-1:0]      o_found_value
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = htlp_pkg::ST_W + htlp_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [1:0]                  r_cmd, n_cmd;
    logic [htlp_pkg::KEY_W-1:0]  r_key, n_key;
    logic [VALUE_WIDTH-1:0]      r_val, n_val;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_free_found, n_free_found;
    logic [IDX_W-1:0]            r_free_idx, n_free_idx;
    logic [1:0]                  r_res_status, n_res_status;
    logic [VALUE_WIDTH-1:0]      r_res_value, n_res_value;
    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_out_status, n_out_status;
    logic [VALUE_WIDTH-1:0]      r_out_value, n_out_value;

    // RAM ports
    logic                        ent_we;
    logic [IDX_W-1:0]            ent_waddr;
    logic [ENT_W-1:0]            ent_wdata;
    logic [ENT_W-1:0]            ent_rdata;
    logic                        val_we;
    logic [IDX_W-1:0]            val_waddr;
    logic [VALUE_WIDTH-1:0]      val_wdata;
    logic [VALUE_WIDTH-1:0]      val_rdata;

    // Home slot unit
    logic                        home_start;
    logic                        home_done;
    logic [IDX_W-1:0]            home_slot;

    // Probe step decode
    logic [htlp_pkg::ST_W-1:0]   slot_st;
    logic                        slot_empty;
    logic                        slot_hit;
    logic                        slot_free;
    logic                        probe_last;
    logic                        free_ok;
    logic [IDX_W-1:0]            free_at;
    logic [IDX_W-1:0]            idx_next;
    logic                        in_accept;

    assign in_accept  = i_valid && !o_stall;
    assign home_start = in_accept && (i_command != htlp_pkg::CMD_UNUSED);

    htlp_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (home_start),
        .i_key   (i_lookup_key),
        .o_done  (home_done),
        .o_slot  (home_slot)
    );

    // Key and slot state store
    htlp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (n_idx),
        .o_rdata (ent_rdata)
    );

    // Value store
    htlp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (n_idx),
        .o_rdata (val_rdata)
    );

    // Decode of the slot read for r_idx
    assign slot_st    = ent_rdata[ENT_W-1 -: htlp_pkg::ST_W];
    assign slot_empty = (slot_st == htlp_pkg::ST_EMPTY);
    assign slot_hit   = (slot_st == htlp_pkg::ST_USED) &&
                        (ent_rdata[htlp_pkg::KEY_W-1:0] == r_key);
    assign slot_free  = (slot_st != htlp_pkg::ST_USED);
    assign probe_last = (r_count == CNT_W'(SLOTS - 1));
    assign free_ok    = r_free_found || slot_free;
    assign free_at    = r_free_found ? r_free_idx : r_idx;
    assign idx_next   = (r_idx == IDX_W'(SLOTS - 1)) ? '0 : r_idx + 1'b1;

    // Next-state and RAM write logic
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_count      = r_count;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;

        ent_we    = 1'b0;
        ent_waddr = r_idx;
        ent_wdata = {htlp_pkg::ST_EMPTY, r_key};
        val_we    = 1'b0;
        val_waddr = r_idx;
        val_wdata = r_val;

        // Output register drains whenever the receiver takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = r_idx;
                ent_wdata = {htlp_pkg::ST_EMPTY, {htlp_pkg::KEY_W{1'b0}}};
                if (r_idx == IDX_W'(SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    n_cmd        = i_command;
                    n_key        = i_lookup_key;
                    n_val        = i_entry_value;
                    n_count      = '0;
                    n_free_found = 1'b0;
                    n_res_status = htlp_pkg::RES_MISS;
                    n_res_value  = '0;
                    n_state      = (i_command == htlp_pkg::CMD_UNUSED) ? S_DONE : S_HASH;
                end
            end

            S_HASH: begin
                if (home_done) begin
                    n_idx   = home_slot;
                    n_state = S_PROBE;
                end
            end

            S_PROBE: begin
                if (slot_empty || slot_hit || probe_last) begin
                    n_state = S_DONE;
                    case (r_cmd)
                        htlp_pkg::CMD_STORE: begin
                            if (slot_hit) begin
                                val_we       = 1'b1;
                                val_waddr    = r_idx;
                                n_res_status = htlp_pkg::RES_OK;
                            end else if (free_ok) begin
                                ent_we       = 1'b1;
                                ent_waddr    = free_at;
                                ent_wdata    = {htlp_pkg::ST_USED, r_key};
                                val_we       = 1'b1;
                                val_waddr    = free_at;
                                n_res_status = htlp_pkg::RES_OK;
                            end else begin
                                n_res_status = htlp_pkg::RES_FULL;
                            end
                        end
                        htlp_pkg::CMD_GET: begin
                            if (slot_hit) begin
                                n_res_status = htlp_pkg::RES_HIT;
                                n_res_value  = val_rdata;
                            end
                        end
                        htlp_pkg::CMD_REMOVE: begin
                            if (slot_hit) begin
                                ent_we       = 1'b1;
                                ent_waddr    = r_idx;
                                ent_wdata    = {htlp_pkg::ST_TOMB, r_key};
                                n_res_status = htlp_pkg::RES_OK;
                            end
                        end
                        default: begin
                            n_res_status = htlp_pkg::RES_MISS;
                        end
                    endcase
                end else begin
                    // Keep looking; remember the first reusable slot
                    if (!r_free_found && slot_free) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    n_count = r_count + 1'b1;
                    n_idx   = idx_next;
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_count      <= n_count;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_value;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for hash_table_linear_probe_top.
// A clocked driver and monitor sit around the block. A shadow table predicts
// the status and value of every command.
// Depends on htlp_pkg and hash_table_linear_probe_top.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_SLOTS  = 64;
    localparam int VAL_W      = 64;
    localparam int POOL_SIZE  = 96;
    localparam int RAND_ITEMS = 1250;
    localparam int CALM_TAIL  = 150;
    localparam int DRAIN_WAIT = 80;

    typedef struct {
        logic [1:0]                 cmd;
        logic [htlp_pkg::KEY_W-1:0] key;
        logic [VAL_W-1:0]           val;
    } t_op;

    typedef struct {
        htlp_pkg::t_res   status;
        logic [VAL_W-1:0] value;
    } t_reply;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_command = '0;
    logic [htlp_pkg::KEY_W-1:0] i_lookup_key = '0;
    logic [VAL_W-1:0]           i_entry_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [1:0]                 o_status;
    logic [VAL_W-1:0]           o_found_value;

    // shadow copy of the table
    logic [htlp_pkg::KEY_W-1:0] shadow_key [TBL_SLOTS];
    logic [VAL_W-1:0]           shadow_val [TBL_SLOTS];
    htlp_pkg::t_slot_st         shadow_st  [TBL_SLOTS];

    t_op                        ops_to_send [$];
    t_reply                     table_replies [$];
    logic [htlp_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    int                     errors = 0;
    logic                   in_taken = 1'b0;
    logic                   calm = 1'b0;
    logic                   idle_on = 1'b1;
    int                     mood_left = 0;
    int                     send_gap = 0;
    int                     stall_left = 0;

    hash_table_linear_probe_top #(
        .SLOTS       (TBL_SLOTS),
        .VALUE_WIDTH (VAL_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_lookup_key  (i_lookup_key),
        .i_entry_value (i_entry_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_value (o_found_value)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Applies one command to the shadow table and returns its reply.
    // Probe starts at the home slot, stops at an empty slot, a matching key or after a full lap.
    task automatic table_apply(input logic [1:0] cmd,
                               input logic [htlp_pkg::KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, output t_reply rep);
        int  idx;
        int  hit;
        int  first_free;
        int  i;
        bit  done;
        idx        = int'((key >> htlp_pkg::HASH_SHIFT) % TBL_SLOTS);
        hit        = TBL_SLOTS;
        first_free = TBL_SLOTS;
        done       = 1'b0;
        for (i = 0; i < TBL_SLOTS && !done; i++) begin
            if (shadow_st[idx] == htlp_pkg::ST_EMPTY) begin
                if (first_free == TBL_SLOTS)
                    first_free = idx;
                done = 1'b1;
            end else if (shadow_st[idx] == htlp_pkg::ST_USED) begin
                if (shadow_key[idx] == key) begin
                    hit  = idx;
                    done = 1'b1;
                end
            end else if (first_free == TBL_SLOTS) begin
                first_free = idx;
            end
            if (!done)
                idx = (idx + 1) % TBL_SLOTS;
        end

        rep.status = htlp_pkg::RES_MISS;
        rep.value  = '0;
        if (cmd == htlp_pkg::CMD_STORE) begin
            if (hit < TBL_SLOTS) begin
                shadow_val[hit] = val;
                rep.status = htlp_pkg::RES_OK;
            end else if (first_free < TBL_SLOTS) begin
                shadow_key[first_free] = key;
                shadow_val[first_free] = val;
                shadow_st[first_free]  = htlp_pkg::ST_USED;
                rep.status = htlp_pkg::RES_OK;
            end else begin
                rep.status = htlp_pkg::RES_FULL;
            end
        end else if (cmd == htlp_pkg::CMD_GET) begin
            if (hit < TBL_SLOTS) begin
                rep.status = htlp_pkg::RES_HIT;
                rep.value  = shadow_val[hit];
            end
        end else if (cmd == htlp_pkg::CMD_REMOVE) begin
            if (hit < TBL_SLOTS) begin
                shadow_st[hit] = htlp_pkg::ST_TOMB;
                rep.status = htlp_pkg::RES_OK;
            end
        end
    endtask

    task automatic push_op(input logic [1:0] cmd, input logic [htlp_pkg::KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
        t_op op;
        op.cmd = cmd;
        op.key = key;
        op.val = val;
        ops_to_send.push_back(op);
    endtask

    // payloads lean toward the extremes now and then
    function automatic logic [VAL_W-1:0] rand_payload();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Alternates stretches with random idling and stretches without any
    always @(negedge i_clk) begin
        if (mood_left > 0) begin
            mood_left <= mood_left - 1;
        end else begin
            idle_on   <= ($urandom_range(0, 3) != 0);
            mood_left <= $urandom_range(50, 400);
        end
    end

    // Input driver: holds each transaction until accepted, idles in bursts
    always @(negedge i_clk) begin : drive_in
        t_op next_op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            calm <= (ops_to_send.size() < CALM_TAIL);
            if (send_gap > 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
                i_valid  <= 1'b0;
                send_gap <= $urandom_range(0, 18);
            end else if (ops_to_send.size() > 0) begin
                next_op       = ops_to_send.pop_front();
                i_valid       <= 1'b1;
                i_command     <= next_op.cmd;
                i_lookup_key  <= next_op.key;
                i_entry_value <= next_op.val;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance
    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply fresh;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (table_replies.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with none expected",
                                              o_status));
                end else begin
                    want = table_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_found_value !== want.value)
                        report_mismatch($sformatf("found_value %h, expected %h",
                                                  o_found_value, want.value));
                end
            end
            if (i_valid && !o_stall) begin
                table_apply(i_command, i_lookup_key, i_entry_value, fresh);
                table_replies.push_back(fresh);
            end
            in_taken <= i_valid && !o_stall;
        end
    end

    // Run limit
    initial begin
        #7_000_000;
        $display("** hash_table_linear_probe_top: FAILED **");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [htlp_pkg::KEY_W-1:0] k_zero;
        logic [htlp_pkg::KEY_W-1:0] k_ones;
        logic [htlp_pkg::KEY_W-1:0] k_wrap;
        logic [htlp_pkg::KEY_W-1:0] k_alias;
        int               order [POOL_SIZE];
        int               total;
        int               kind;
        int               j;
        int               p;
        int               t;
        int               sel;
        bit               first_phase;

        for (j = 0; j < TBL_SLOTS; j++)
            shadow_st[j] = htlp_pkg::ST_EMPTY;

        // k_zero and k_alias share home slot 0; k_ones and k_wrap share slot 63
        k_zero  = '0;
        k_alias = 64'h8000_0000_0000_0000;
        k_ones  = '1;
        k_wrap  = 64'h0123_4567_89AB_CDF8;

        // directed: empty miss, collisions, overwrite, wrap, tombstones
        push_op(htlp_pkg::CMD_GET,    k_zero,  '1);
        push_op(htlp_pkg::CMD_STORE,  k_zero,  '0);
        push_op(htlp_pkg::CMD_GET,    k_zero,  '0);
        push_op(htlp_pkg::CMD_STORE,  k_alias, '1);
        push_op(htlp_pkg::CMD_GET,    k_alias, '0);
        push_op(htlp_pkg::CMD_STORE,  k_zero,  64'h5555_5555_5555_5555);
        push_op(htlp_pkg::CMD_GET,    k_zero,  '0);
        push_op(htlp_pkg::CMD_STORE,  k_ones,  64'hAAAA_AAAA_AAAA_AAAA);
        push_op(htlp_pkg::CMD_STORE,  k_wrap,  64'h1);
        push_op(htlp_pkg::CMD_GET,    k_wrap,  '0);
        push_op(htlp_pkg::CMD_REMOVE, k_zero,  '0);
        push_op(htlp_pkg::CMD_GET,    k_alias, '0);
        push_op(htlp_pkg::CMD_GET,    k_zero,  '0);
        push_op(htlp_pkg::CMD_REMOVE, k_zero,  '1);
        push_op(htlp_pkg::CMD_GET,    k_wrap,  '0);
        push_op(htlp_pkg::CMD_STORE,  k_zero,  64'h8000_0000_0000_0001);
        push_op(htlp_pkg::CMD_GET,    k_zero,  '0);
        push_op(htlp_pkg::CMD_REMOVE, k_alias, '0);
        // key found beyond a tombstone is overwritten in place
        push_op(htlp_pkg::CMD_STORE,  k_wrap,  64'h7FFF_FFFF_FFFF_FFFF);
        push_op(htlp_pkg::CMD_GET,    k_wrap,  '0);
        push_op(htlp_pkg::CMD_GET,    k_alias, '0);
        push_op(htlp_pkg::CMD_UNUSED, k_ones,  '1);
        push_op(htlp_pkg::CMD_GET,    k_ones,  '0);

        // key pool: a third crowd onto homes 60..63 for long, wrapping chains
        for (j = 0; j < POOL_SIZE; j++) begin
            key_pool[j] = {$urandom, $urandom};
            if (j < POOL_SIZE / 3)
                key_pool[j][8:3] = 6'($urandom_range(60, 63));
        end

        total = 0;
        first_phase = 1'b1;
        while (total < RAND_ITEMS) begin
            kind = first_phase ? 0 : $urandom_range(0, 9);
            first_phase = 1'b0;
            if (kind <= 1) begin
                // fill past capacity with distinct keys, then read back
                for (j = 0; j < POOL_SIZE; j++)
                    order[j] = j;
                for (j = POOL_SIZE - 1; j > 0; j--) begin
                    p = $urandom_range(0, j);
                    t = order[j];
                    order[j] = order[p];
                    order[p] = t;
                end
                for (j = 0; j < 70; j++)
                    push_op(htlp_pkg::CMD_STORE, key_pool[order[j]], rand_payload());
                for (j = 0; j < 30; j++)
                    push_op(htlp_pkg::CMD_GET, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                            rand_payload());
                total += 100;
            end else if (kind <= 5) begin
                // mixed traffic over the pool
                for (j = 0; j < 60; j++) begin
                    sel = $urandom_range(0, 9);
                    push_op(sel <= 3 ? htlp_pkg::CMD_STORE :
                            (sel <= 7 ? htlp_pkg::CMD_GET : htlp_pkg::CMD_REMOVE),
                            key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
                end
                total += 60;
            end else if (kind <= 7) begin
                // heavy removal leaves tombstones, then probe and refill
                for (j = 0; j < 40; j++)
                    push_op(htlp_pkg::CMD_REMOVE,
                            key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
                for (j = 0; j < 15; j++)
                    push_op(htlp_pkg::CMD_GET,
                            key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
                for (j = 0; j < 15; j++)
                    push_op(htlp_pkg::CMD_STORE,
                            key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
                total += 70;
            end else begin
                // noise: arbitrary keys and commands, the unused one included
                for (j = 0; j < 20; j++)
                    push_op(2'($urandom_range(0, 3)), {$urandom, $urandom},
                            rand_payload());
                total += 20;
            end
        end

        // reset, then let the traffic run
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() > 0 || i_valid)
            @(negedge i_clk);
        while (table_replies.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0)
            $display("** hash_table_linear_probe_top: PASSED **");
        else
            $display("** hash_table_linear_probe_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
